[design/afsc_pkg.sv]
`default_nettype none

package afsc_pkg;

   // Width of an unpacked mantissa, hidden bit included.
   localparam int unsigned MantBits = 24;
   localparam int unsigned SigBitsWidth = 5;
   localparam int unsigned SigBitsMax = 23;
   localparam logic [SigBitsWidth-1:0] SigBitsReset = 5'd23;

   // Biased exponent offsets for the frexp-style unpacking.
   localparam int NormBias = 126;
   localparam int DenormBias = 148;

   typedef struct packed {
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic        last;
   } req_item_type;

   typedef struct packed {
      logic element_match;
      logic block_match;
      logic block_done;
   } rsp_item_type;

   typedef struct packed {
      logic [MantBits-1:0] mant;
      logic signed [9:0]   expo;
   } unpacked_type;

   // Shift applied to both mantissas: MantBits minus keep_bits clamped to 1..23.
   function automatic logic [SigBitsWidth-1:0] sig_shift(input logic [SigBitsWidth-1:0] sig);
      logic [SigBitsWidth-1:0] s;
      s = sig;
      if (s == '0) begin
         s = SigBitsWidth'(1);
      end else if (s > SigBitsWidth'(SigBitsMax)) begin
         s = SigBitsWidth'(SigBitsMax);
      end
      return SigBitsWidth'(MantBits) - s;
   endfunction

endpackage

`default_nettype wire

[design/approx_float32_stream_compare.sv]
`default_nettype none

// Approximate single-precision stream compare. Each item is a pair of raw
// IEEE single values plus a last marker; each result reports whether the pair
// matches within one unit in the leading keep_bits mantissa bits, the running
// AND over the current block, and a copy of last. The block takes one item
// per clock while the result side keeps up, and gives one result per item:
// an item is latched into an input register, compared by combinational logic,
// and moves into the result register when that register is empty or being
// read out. The input register refills in the same cycle that it hands its
// item on, so back-to-back items flow without bubbles while the result side
// keeps up. The user must write keep_bits through the csr port only while no
// item is in flight; the block itself does not enforce this. keep_bits resets
// to 23.

module approx_float32_stream_compare (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire afsc_pkg::req_item_type                req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output afsc_pkg::rsp_item_type                     rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [afsc_pkg::SigBitsWidth-1:0]     csr_keep_bits
);

   logic                                  csr_take;
   logic [afsc_pkg::SigBitsWidth-1:0]     shift_val_ff;
   logic [afsc_pkg::SigBitsWidth-1:0]     shift_val_in;
   logic                                  s1_valid_ff;
   logic                                  s1_valid_in;
   afsc_pkg::req_item_type                s1_data_ff;
   logic                                  out_valid_ff;
   logic                                  out_valid_in;
   afsc_pkg::rsp_item_type                out_data_ff;
   afsc_pkg::rsp_item_type                out_data_in;
   logic                                  all_match_ff;
   logic                                  all_match_in;
   logic                                  out_open;
   logic                                  s1_move;
   logic                                  req_take;
   logic                                  element_match;

   afsc_pair_cmp u_pair_cmp (
      .value_a (s1_data_ff.value_a),
      .value_b (s1_data_ff.value_b),
      .shift   (shift_val_ff),
      .match   (element_match)
   );

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      out_open = !out_valid_ff || rsp_ready;
      s1_move = s1_valid_ff && out_open;
      req_ready = !s1_valid_ff || out_open;
      req_take = req_valid && req_ready;

      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);

      out_data_in.element_match = element_match;
      out_data_in.block_match = all_match_ff && element_match;
      out_data_in.block_done = s1_data_ff.last;

      all_match_in = all_match_ff;
      if (s1_move) begin
         all_match_in = s1_data_ff.last ? 1'b1 : out_data_in.block_match;
      end

      shift_val_in = shift_val_ff;
      if (csr_take) begin
         shift_val_in = afsc_pkg::sig_shift(csr_keep_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         all_match_ff <= 1'b1;
         shift_val_ff <= afsc_pkg::sig_shift(afsc_pkg::SigBitsReset);
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         all_match_ff <= all_match_in;
         shift_val_ff <= shift_val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[design/afsc_pair_cmp.sv]
`default_nettype none

module afsc_pair_cmp (
   input  wire logic [31:0]                           value_a,
   input  wire logic [31:0]                           value_b,
   input  wire logic [afsc_pkg::SigBitsWidth-1:0]     shift,
   output logic                                       match
);

   function automatic afsc_pkg::unpacked_type unpack(input logic [30:0] mag);
      afsc_pkg::unpacked_type r;
      logic [7:0]  bexp;
      logic [22:0] frac;
      logic [4:0]  p;
      bexp = mag[30:23];
      frac = mag[22:0];
      p = '0;
      // Position of the leading one of a denormal fraction.
      for (int i = 0; i < 23; i++) begin
         if (frac[i]) begin
            p = 5'(i);
         end
      end
      if (bexp != 8'd0) begin
         r.mant = {1'b1, frac};
         r.expo = $signed({2'b00, bexp}) - 10'(afsc_pkg::NormBias);
      end else if (frac == 23'd0) begin
         r.mant = '0;
         r.expo = '0;
      end else begin
         r.mant = {1'b0, frac} << (5'd23 - p);
         r.expo = $signed({5'b00000, p}) - 10'(afsc_pkg::DenormBias);
      end
      return r;
   endfunction

   logic [30:0]                    mag_a;
   logic [30:0]                    mag_b;
   logic                           a_neg;
   logic                           b_neg;
   logic                           b_pos;
   logic                           special;
   logic                           sign_fail;
   afsc_pkg::unpacked_type         ua;
   afsc_pkg::unpacked_type         ub;
   logic [afsc_pkg::MantBits-1:0]  ma;
   logic [afsc_pkg::MantBits-1:0]  mb;
   logic signed [9:0]              ea;
   logic signed [9:0]              eb;
   logic [afsc_pkg::MantBits-1:0]  sa;
   logic [afsc_pkg::MantBits-1:0]  sb;
   logic [afsc_pkg::MantBits:0]    diff;

   always_comb begin
      mag_a = value_a[30:0];
      mag_b = value_b[30:0];
      a_neg = value_a[31] && (mag_a != '0);
      b_neg = value_b[31] && (mag_b != '0);
      b_pos = !value_b[31] && (mag_b != '0);
      special = (mag_a[30:23] == 8'hFF) || (mag_b[30:23] == 8'hFF);
      sign_fail = a_neg ? b_pos : b_neg;

      ua = unpack(mag_a);
      ub = unpack(mag_b);
      ma = ua.mant;
      mb = ub.mant;
      ea = ua.expo;
      eb = ub.expo;
      // Unequal exponents: raise the smaller by one and halve its mantissa, which aligns a pair one apart.
      if (ea < eb) begin
         ea = ea + 10'sd1;
         ma = ma >> 1;
      end else if (eb < ea) begin
         eb = eb + 10'sd1;
         mb = mb >> 1;
      end

      sa = ma >> shift;
      sb = mb >> shift;
      diff = {1'b0, sa} - {1'b0, sb};

      match = !special && !sign_fail && (ea == eb) &&
              ((diff == '0) || (diff == (afsc_pkg::MantBits+1)'(1)) || (diff == '1));
   end

endmodule

`default_nettype wire

[design/afsc_checker.sv]
`default_nettype none

module afsc_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire afsc_pkg::rsp_item_type  rsp_data
);

   logic fail_open_ff;
   logic fail_open_in;

   // Tracks a block whose running match has already dropped.
   always_comb begin
      fail_open_in = fail_open_ff;
      if (rsp_valid && rsp_ready) begin
         fail_open_in = !rsp_data.block_done && !rsp_data.block_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_open_ff <= 1'b0;
      end else begin
         fail_open_ff <= fail_open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_block_and: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_match |-> rsp_data.element_match)
      else $error("block match set on a mismatching item");

   a_block_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fail_open_ff |-> !rsp_data.block_match)
      else $error("block match recovered inside a failed block");

endmodule

bind approx_float32_stream_compare afsc_checker u_afsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int CycleLimit = 200000;
   localparam int PhaseItems = 170;
   localparam int MaxReports = 10;

   typedef struct {
      logic                   is_cfg;
      logic [4:0]             sig;
      afsc_pkg::req_item_type item;
   } stim_entry_type;

   typedef enum int {VAL_ZERO, VAL_DENORM, VAL_SPECIAL, VAL_RAW, VAL_NORMAL} value_kind_type;
   typedef enum int {
      NEAR_SAME, NEAR_LOW_BITS, NEAR_STEP, NEAR_SIGN, NEAR_EXPO, NEAR_OTHER
   } near_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   afsc_pkg::req_item_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   afsc_pkg::rsp_item_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [afsc_pkg::SigBitsWidth-1:0] csr_keep_bits;

   stim_entry_type stim_q[$];
   afsc_pkg::rsp_item_type match_expect_q[$];
   int mismatches = 0;
   int cycles = 0;
   int gap_left;
   int stall_left;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   // Predictor state.
   logic [4:0] cur_keep_bits;
   logic run_and;

   approx_float32_stream_compare uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_keep_bits (csr_keep_bits)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int mant_shift(input logic [4:0] sig);
      int s;
      s = int'(sig);
      if (s < 1) s = 1;
      if (s > 23) s = 23;
      return 24 - s;
   endfunction

   // Split a magnitude into a 24-bit mantissa in [2^23, 2^24), or zero for a zero magnitude, and an exponent.
   function automatic void split_mag(input logic [30:0] mag, output logic [23:0] mant,
                                     output int expo);
      logic [7:0] bexp;
      logic [22:0] frac;
      int p;
      bexp = mag[30:23];
      frac = mag[22:0];
      if (bexp != 8'd0) begin
         mant = {1'b1, frac};
         expo = int'(bexp) - 126;
      end else if (frac == 23'd0) begin
         mant = 24'd0;
         expo = 0;
      end else begin
         p = 22;
         while (!frac[p]) p--;
         mant = {1'b0, frac} << (23 - p);
         expo = p - 148;
      end
   endfunction

   function automatic logic pair_matches(input logic [31:0] a, input logic [31:0] b,
                                         input logic [4:0] sig);
      logic [23:0] ma, mb;
      int ea, eb, sh, diff;
      logic a_neg, b_neg, b_pos;
      a_neg = a[31] && (a[30:0] != 31'd0);
      b_neg = b[31] && (b[30:0] != 31'd0);
      b_pos = !b[31] && (b[30:0] != 31'd0);
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return 1'b0;
      if (a_neg ? b_pos : b_neg) return 1'b0;
      split_mag(a[30:0], ma, ea);
      split_mag(b[30:0], mb, eb);
      if (ea < eb) begin
         ea++;
         ma = ma >> 1;
      end else if (eb < ea) begin
         eb++;
         mb = mb >> 1;
      end
      if (ea != eb) return 1'b0;
      sh = mant_shift(sig);
      diff = int'(ma >> sh) - int'(mb >> sh);
      return (diff >= -1) && (diff <= 1);
   endfunction

   function automatic logic [31:0] random_value();
      value_kind_type kind;
      int r;
      r = $urandom_range(0, 9);
      kind = (r < 4) ? value_kind_type'(r) : VAL_NORMAL;
      case (kind)
         VAL_ZERO:    return {1'($urandom), 31'd0};
         VAL_DENORM:  return {1'($urandom), 8'd0, 23'($urandom_range(1, 32'h7FFFFF))};
         VAL_SPECIAL: return {1'($urandom), 8'hFF, 23'($urandom)};
         VAL_RAW:     return $urandom;
         default:     return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
      endcase
   endfunction

   // A partner for a that lands close to it; clean partners always match a normal a.
   function automatic logic [31:0] nearby_value(input logic [31:0] a, input int sh,
                                                input logic clean);
      logic [31:0] mask;
      logic [31:0] step;
      near_kind_type kind;
      mask = (32'd1 << sh) - 32'd1;
      step = 32'($urandom_range(0, 2)) << sh;
      kind = clean ? near_kind_type'($urandom_range(0, 1))
                   : near_kind_type'($urandom_range(0, 5));
      case (kind)
         NEAR_SAME:     return a;
         NEAR_LOW_BITS: return a ^ ($urandom & mask);
         NEAR_STEP:     return $urandom_range(0, 1) ? a + step : a - step;
         NEAR_SIGN:     return a ^ 32'h8000_0000;
         NEAR_EXPO:     return {a[31], a[30:23] + ($urandom_range(0, 1) ? 8'd1 : 8'hFF),
                                23'($urandom)};
         default:       return random_value();
      endcase
   endfunction

   task automatic add_item(input logic [31:0] a, input logic [31:0] b, input logic last);
      stim_entry_type e;
      e.is_cfg = 1'b0;
      e.sig = '0;
      e.item.value_a = a;
      e.item.value_b = b;
      e.item.last = last;
      stim_q.push_back(e);
   endtask

   task automatic add_cfg(input logic [4:0] sig);
      stim_entry_type e;
      e.is_cfg = 1'b1;
      e.sig = sig;
      e.item = '0;
      stim_q.push_back(e);
   endtask

   task automatic add_phase(input logic [4:0] sig);
      int count, len, sh, i;
      logic clean, noise;
      logic [31:0] a, b, t;
      count = 0;
      sh = mant_shift(sig);
      add_cfg(sig);
      while (count < PhaseItems) begin
         len = $urandom_range(1, 8);
         clean = $urandom_range(0, 1);
         for (i = 0; i < len; i++) begin
            noise = !clean && ($urandom_range(0, 6) == 0);
            if (clean)
               a = {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
            else
               a = random_value();
            b = noise ? $urandom : nearby_value(a, sh, clean);
            if ($urandom_range(0, 1)) begin
               t = a;
               a = b;
               b = t;
            end
            add_item(a, b, i == len - 1);
         end
         count += len;
      end
   endtask

   // Driver: one item or register write at a time, with random gaps between items.
   always @(posedge clock) begin
      logic req_hold, csr_hold, load_req, load_csr;
      stim_entry_type ent;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         csr_valid <= 1'b0;
         csr_keep_bits <= afsc_pkg::SigBitsReset;
         gap_left <= 0;
      end else begin
         req_hold = req_valid && !req_ready;
         csr_hold = csr_valid && !csr_ready;
         load_req = 1'b0;
         load_csr = 1'b0;
         if (!req_hold && !csr_hold) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (stim_q.size() != 0) begin
               ent = stim_q[0];
               if (!ent.is_cfg) begin
                  load_req = 1'b1;
                  req_data <= ent.item;
                  void'(stim_q.pop_front());
                  if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
                  gap_left <= req_calm ? 0 : $urandom_range(0, 3);
               end else if (!req_valid && match_expect_q.size() == 0) begin
                  // The register only changes once every item has come out.
                  load_csr = 1'b1;
                  csr_keep_bits <= ent.sig;
                  void'(stim_q.pop_front());
               end
            end
         end
         req_valid <= req_hold || load_req;
         csr_valid <= csr_hold || load_csr;
      end
   end

   // Monitor: predicts on every accepted item, checks every accepted result.
   always @(posedge clock) begin
      afsc_pkg::rsp_item_type want;
      logic em;
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         cur_keep_bits = afsc_pkg::SigBitsReset;
         run_and = 1'b1;
      end else begin
         if (csr_valid && csr_ready) cur_keep_bits = csr_keep_bits;
         if (req_valid && req_ready) begin
            em = pair_matches(req_data.value_a, req_data.value_b, cur_keep_bits);
            want.element_match = em;
            want.block_match = run_and & em;
            want.block_done = req_data.last;
            run_and = req_data.last ? 1'b1 : want.block_match;
            match_expect_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (match_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("unexpected result item: match=%0b block=%0b done=%0b",
                           rsp_data.element_match, rsp_data.block_match,
                           rsp_data.block_done);
            end else begin
               want = match_expect_q.pop_front();
               if (rsp_data.element_match !== want.element_match ||
                   rsp_data.block_match !== want.block_match ||
                   rsp_data.block_done !== want.block_done) begin
                  mismatches++;
                  if (mismatches <= MaxReports) begin
                     $write("result mismatch: expected match=%0b block=%0b done=%0b, ",
                            want.element_match, want.block_match, want.block_done);
                     $display("got match=%0b block=%0b done=%0b",
                              rsp_data.element_match, rsp_data.block_match,
                              rsp_data.block_done);
                  end
               end
            end
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            w = rsp_calm ? 0 : $urandom_range(0, 3);
            stall_left <= w;
            rsp_ready <= (w == 0);
         end else if (!rsp_ready) begin
            if (stall_left <= 1) rsp_ready <= 1'b1;
            if (stall_left > 0) stall_left <= stall_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      logic [4:0] phase_sigs[10];
      reset = 1'b1;

      // Directed part, run at the reset setting first.
      add_item(32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_item(32'h3F80_0000, 32'h3F80_0001, 1'b0);
      add_item(32'h3F80_0000, 32'h3F80_0004, 1'b1);
      add_item(32'h3F80_0000, 32'h3F7F_FFFF, 1'b0);
      add_item(32'h3F80_0000, 32'h3E80_0000, 1'b1);
      add_item(32'h0000_0000, 32'h0000_0000, 1'b0);
      add_item(32'h0000_0000, 32'h8000_0000, 1'b0);
      add_item(32'h8000_0000, 32'h3F80_0000, 1'b0);
      add_item(32'hBF80_0000, 32'h8000_0000, 1'b1);
      add_item(32'hBF80_0000, 32'h3F80_0000, 1'b0);
      add_item(32'h3F80_0000, 32'hBF80_0000, 1'b0);
      add_item(32'hBF80_0000, 32'hBF80_0001, 1'b1);
      add_item(32'h7FC0_0000, 32'h7FC0_0000, 1'b0);
      add_item(32'h7F80_0000, 32'h7F80_0000, 1'b0);
      add_item(32'hFF80_0000, 32'h3F80_0000, 1'b0);
      add_item(32'h3F80_0000, 32'h7FFF_FFFF, 1'b1);
      add_item(32'h0000_0001, 32'h0000_0001, 1'b0);
      add_item(32'h0000_0001, 32'h0000_0002, 1'b0);
      add_item(32'h007F_FFFF, 32'h0080_0000, 1'b1);
      add_item(32'h7F7F_FFFF, 32'h7F7F_FFFE, 1'b0);
      add_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      add_item(32'h0000_0000, 32'h0000_0001, 1'b1);
      add_item(32'h3F80_0000, 32'h3F80_0000, 1'b1);
      add_cfg(5'd1);
      add_item(32'h3F80_0000, 32'h3FFF_FFFF, 1'b1);
      add_item(32'h3F80_0000, 32'h4000_0000, 1'b1);

      phase_sigs = '{5'd0, 5'd31, 5'd24, 5'd23, 5'd2, 5'd12, 5'($urandom),
                     5'($urandom), 5'd22, 5'd1};
      foreach (phase_sigs[i]) add_phase(phase_sigs[i]);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_valid || csr_valid || match_expect_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && match_expect_q.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
